@@ src/two_way_sorted_merge_defines.svh @@
// Assertion macros for the checker file of the merge unit.
`ifndef TWO_WAY_SORTED_MERGE_DEFINES_SVH
`define TWO_WAY_SORTED_MERGE_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define TSM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("merge unit assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TSM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("merge unit assertion failed");

`endif

@@ src/tsm_pkg.sv @@
package tsm_pkg;

  localparam int LIST_DEPTH = 256;
  localparam int PTR_W      = $clog2(LIST_DEPTH);
  localparam int FILL_W     = $clog2(LIST_DEPTH + 1);
  localparam int DATA_W     = 32;

  localparam logic [1:0] ACT_PUSH_A    = 2'd0;
  localparam logic [1:0] ACT_PUSH_B    = 2'd1;
  localparam logic [1:0] ACT_POP       = 2'd2;
  localparam logic [1:0] ACT_POP_SPARE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] popped_value;
    logic                     from_list;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH,
    S_POP
  } state_t;

  typedef struct packed {
    logic load;
    logic exec_push;
    logic exec_pop;
  } ctl_cmd_t;

  // Any action with the upper bit set is a pop, including the unused code.
  function automatic logic act_is_pop(input logic [1:0] action);
    return action[1];
  endfunction

endpackage

@@ src/tsm_ram.sv @@
module tsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/tsm_ctrl.sv @@
module tsm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        action,
  output logic              busy,
  output logic              out_valid,
  output tsm_pkg::ctl_cmd_t cmd
);
  import tsm_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = act_is_pop(action) ? S_POP : S_PUSH;
        end
      end
      S_PUSH:  state_nxt = S_IDLE;
      S_POP:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_PUSH: begin
        cmd.exec_push = 1'b1;
        out_valid     = 1'b1;
      end
      S_POP: begin
        cmd.exec_pop = 1'b1;
        out_valid    = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

@@ src/tsm_datapath.sv @@
module tsm_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  tsm_pkg::ctl_cmd_t  cmd,
  input  tsm_pkg::in_item_t  in_item,
  output tsm_pkg::out_item_t out_item
);
  import tsm_pkg::*;

  in_item_t item_r;

  logic [PTR_W-1:0]  rd_ptr_a_r, rd_ptr_a_nxt, wr_ptr_a_r, wr_ptr_a_nxt;
  logic [PTR_W-1:0]  rd_ptr_b_r, rd_ptr_b_nxt, wr_ptr_b_r, wr_ptr_b_nxt;
  logic [FILL_W-1:0] fill_a_r, fill_a_nxt, fill_b_r, fill_b_nxt;

  logic [DATA_W-1:0] head_a, head_b;
  logic              full_a, full_b, empty_a, empty_b, both_empty;
  logic              sel_b, take_b, we_a, we_b, pop_a, pop_b;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(LIST_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  tsm_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (wr_ptr_a_r),
    .wdata (item_r.value),
    .raddr (rd_ptr_a_r),
    .rdata (head_a)
  );

  tsm_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (wr_ptr_b_r),
    .wdata (item_r.value),
    .raddr (rd_ptr_b_r),
    .rdata (head_b)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_a_r <= '0;
      wr_ptr_a_r <= '0;
      fill_a_r   <= '0;
      rd_ptr_b_r <= '0;
      wr_ptr_b_r <= '0;
      fill_b_r   <= '0;
    end else begin
      rd_ptr_a_r <= rd_ptr_a_nxt;
      wr_ptr_a_r <= wr_ptr_a_nxt;
      fill_a_r   <= fill_a_nxt;
      rd_ptr_b_r <= rd_ptr_b_nxt;
      wr_ptr_b_r <= wr_ptr_b_nxt;
      fill_b_r   <= fill_b_nxt;
    end
  end

  assign full_a     = (fill_a_r == FILL_W'(LIST_DEPTH));
  assign full_b     = (fill_b_r == FILL_W'(LIST_DEPTH));
  assign empty_a    = (fill_a_r == '0);
  assign empty_b    = (fill_b_r == '0);
  assign both_empty = empty_a && empty_b;
  assign sel_b      = (item_r.action == ACT_PUSH_B);

  // The heads are read every idle cycle, so they are current in the pop beat.
  assign take_b = empty_a || (!empty_b && ($signed(head_b) < $signed(head_a)));

  assign we_a  = cmd.exec_push && !sel_b && !full_a;
  assign we_b  = cmd.exec_push && sel_b && !full_b;
  assign pop_a = cmd.exec_pop && !both_empty && !take_b;
  assign pop_b = cmd.exec_pop && !both_empty && take_b;

  always_comb begin
    wr_ptr_a_nxt = we_a ? wrap_inc(wr_ptr_a_r) : wr_ptr_a_r;
    wr_ptr_b_nxt = we_b ? wrap_inc(wr_ptr_b_r) : wr_ptr_b_r;
    rd_ptr_a_nxt = pop_a ? wrap_inc(rd_ptr_a_r) : rd_ptr_a_r;
    rd_ptr_b_nxt = pop_b ? wrap_inc(rd_ptr_b_r) : rd_ptr_b_r;
    fill_a_nxt   = fill_a_r;
    fill_b_nxt   = fill_b_r;
    if (we_a) begin
      fill_a_nxt = fill_a_r + FILL_W'(1);
    end else if (pop_a) begin
      fill_a_nxt = fill_a_r - FILL_W'(1);
    end
    if (we_b) begin
      fill_b_nxt = fill_b_r + FILL_W'(1);
    end else if (pop_b) begin
      fill_b_nxt = fill_b_r - FILL_W'(1);
    end
  end

  always_comb begin
    out_item = '0;
    if (act_is_pop(item_r.action)) begin
      if (both_empty) begin
        out_item.status = ST_EMPTY;
      end else begin
        out_item.status       = ST_OK;
        out_item.popped_value = take_b ? head_b : head_a;
        out_item.from_list    = take_b;
      end
    end else begin
      out_item.status = (sel_b ? full_b : full_a) ? ST_FULL : ST_OK;
    end
  end

endmodule

@@ src/two_way_sorted_merge.sv @@
// Two-list merge unit with two bounded FIFO lists of signed 32-bit values.
// Input channel: an item (action, value) is accepted at a rising edge where
// start is high and busy is low. Action push A or push B appends the value to
// that list unless it is full; a pop removes the smaller head, list A on a tie.
// Result channel: every item gives exactly one result beat on out_item,
// marked by out_valid for one cycle. The receiver cannot stall; the block
// never holds a result back.
// Timing: the result beat is the cycle right after the accepting edge, and
// busy is high during that cycle, so a new item is not accepted before the
// result beat is over. Both lists live in RAMs with a registered read port;
// the heads are read in the idle cycle and compared in the result cycle.
// Reset (rst_n low, synchronous) empties both lists and returns to idle.
// RAM contents are not cleared; only entries that were pushed are read.
module two_way_sorted_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tsm_pkg::in_item_t  in_item,
  output logic               out_valid,
  output tsm_pkg::out_item_t out_item
);
  import tsm_pkg::*;

  ctl_cmd_t cmd;

  tsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .action    (in_item.action),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  tsm_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

@@ src/tsm_checker.sv @@
`include "two_way_sorted_merge_defines.svh"

module tsm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input tsm_pkg::out_item_t out_item
);
  import tsm_pkg::*;

  logic accept;
  logic fail_beat;
  assign accept    = start && !busy;
  assign fail_beat = out_valid && (out_item.status != ST_OK);

  `TSM_ASSERT_NXT(a_accept_gives_beat, accept, out_valid)
  `TSM_ASSERT_NXT(a_single_beat, out_valid, !out_valid)
  `TSM_ASSERT_IMP(a_beat_while_busy, out_valid, busy && $past(accept))
  `TSM_ASSERT_IMP(a_failed_beat_zero, fail_beat, (out_item.popped_value == '0) && !out_item.from_list)

endmodule

bind two_way_sorted_merge tsm_checker u_tsm_checker (.*);
